### design/pcu_pkg.sv
// pcu_pkg: shared types and constants of the periodic coordinate unwrap unit.
// Payload structs, lane status struct and register indexes; no dependencies.

package pcu_pkg;

    localparam int CoordW   = 32;
    localparam int LenW     = 31;
    localparam int DiffW    = 33;
    localparam int MagW     = 33;
    localparam int NumW     = 34;
    localparam int NlW      = 34;
    localparam int DivSteps = 34;
    localparam int CntW     = 6;
    localparam int CfgIdxW  = 2;

    localparam logic [CfgIdxW-1:0] CfgLenX = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgLenY = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgLenZ = 2'd2;

    typedef struct packed {
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic                     first_atom;
    } item_t;

    typedef struct packed {
        logic signed [CoordW-1:0] fixed_x;
        logic signed [CoordW-1:0] fixed_y;
        logic signed [CoordW-1:0] fixed_z;
    } result_t;

    // what one lane reports to the merge stage
    typedef struct packed {
        logic           done;
        logic           neg;
        logic [NlW-1:0] nl;
    } lane_status_t;

endpackage

### design/pcu_lane.sv
// pcu_lane: one axis of the unwrap unit; finds the whole-cell shift n*L
// with an iterative restoring divider. Depends on pcu_pkg.

module pcu_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               ack,
    input  logic signed [pcu_pkg::CoordW-1:0]  coord,
    input  logic signed [pcu_pkg::CoordW-1:0]  prev,
    input  logic        [pcu_pkg::LenW-1:0]    len,
    input  logic                               first,
    output pcu_pkg::lane_status_t              status
);

    typedef enum logic [2:0] {
        L_IDLE, L_DIFF, L_ABS, L_NUM, L_DIV, L_NL, L_DONE
    } lane_state_t;

    lane_state_t                       state_reg;
    logic [pcu_pkg::DiffW-1:0]         diff_reg;
    logic [pcu_pkg::MagW-1:0]          mag_reg;
    logic                              neg_reg;
    logic [pcu_pkg::NumW-1:0]          num_reg;
    logic [pcu_pkg::LenW:0]            rem_reg;
    logic [pcu_pkg::CntW-1:0]          cnt_reg;
    logic [pcu_pkg::NlW-1:0]           nl_reg;

    logic [pcu_pkg::DiffW-1:0]         diff_next;
    logic [pcu_pkg::LenW:0]            divisor;
    logic [pcu_pkg::LenW+1:0]          trial;
    logic                              qbit;
    logic [pcu_pkg::LenW:0]            rem_next;
    logic [pcu_pkg::NlW:0]             nl_sum;

    assign diff_next = {coord[pcu_pkg::CoordW-1], coord} - {prev[pcu_pkg::CoordW-1], prev};
    assign divisor   = {len, 1'b0};
    assign trial     = {rem_reg, num_reg[pcu_pkg::NumW-1]};
    assign qbit      = (trial >= {1'b0, divisor});
    // the remainder stays below 2L and needs the full LenW+1 bits
    assign rem_next  = qbit ? (pcu_pkg::LenW+1)'(trial - {1'b0, divisor})
                            : trial[pcu_pkg::LenW:0];
    // (2|d| + L - rem) is twice the shift and always even
    assign nl_sum    = {1'b0, mag_reg, 1'b0} + {4'b0, len} - {3'b0, rem_reg};

    assign status.done = (state_reg == L_DONE);
    assign status.neg  = neg_reg;
    assign status.nl   = nl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                        state_reg <= L_DIFF;
                end
                L_DIFF:
                begin
                    if (first || (len == '0))
                    begin
                        // pass through: no cells removed
                        nl_reg    <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= L_DONE;
                    end
                    else
                    begin
                        diff_reg  <= diff_next;
                        state_reg <= L_ABS;
                    end
                end
                L_ABS:
                begin
                    neg_reg   <= diff_reg[pcu_pkg::DiffW-1];
                    mag_reg   <= diff_reg[pcu_pkg::DiffW-1] ? (~diff_reg + 1'b1) : diff_reg;
                    state_reg <= L_NUM;
                end
                L_NUM:
                begin
                    num_reg   <= {mag_reg, 1'b0} + {3'b0, len};
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    rem_reg <= rem_next;
                    num_reg <= {num_reg[pcu_pkg::NumW-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pcu_pkg::CntW'(pcu_pkg::DivSteps - 1))
                        state_reg <= L_NL;
                end
                L_NL:
                begin
                    nl_reg    <= nl_sum[pcu_pkg::NlW:1];
                    state_reg <= L_DONE;
                end
                L_DONE:
                begin
                    if (ack)
                        state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

endmodule

### design/pcu_merge.sv
// pcu_merge: combines the three lane shifts with the held coordinates,
// saturates, and holds the result register and the chain state. Depends on pcu_pkg.

module pcu_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  pcu_pkg::item_t        item,
    input  pcu_pkg::lane_status_t lane_x,
    input  pcu_pkg::lane_status_t lane_y,
    input  pcu_pkg::lane_status_t lane_z,
    input  logic                  result_ready,
    output logic                  result_valid,
    output pcu_pkg::result_t      result,
    output pcu_pkg::result_t      prev
);

    localparam int WideW = pcu_pkg::CoordW + 4;

    function automatic logic signed [pcu_pkg::CoordW-1:0] apply_shift(
        input logic signed [pcu_pkg::CoordW-1:0] coord,
        input pcu_pkg::lane_status_t             lane
    );
        logic signed [WideW-1:0] c;
        logic signed [WideW-1:0] s;
        logic signed [WideW-1:0] r;
        c = WideW'(coord);
        s = $signed({2'b00, lane.nl});
        r = lane.neg ? (c + s) : (c - s);
        if (r > WideW'(signed'(32'sh7FFF_FFFF)))
            apply_shift = 32'sh7FFF_FFFF;
        else if (r < WideW'(signed'(32'sh8000_0000)))
            apply_shift = 32'sh8000_0000;
        else
            apply_shift = r[pcu_pkg::CoordW-1:0];
    endfunction

    logic             result_valid_reg;
    pcu_pkg::result_t result_reg;
    pcu_pkg::result_t prev_reg;
    pcu_pkg::result_t result_next;

    always_comb
    begin
        result_next.fixed_x = apply_shift(item.coord_x, lane_x);
        result_next.fixed_y = apply_shift(item.coord_y, lane_y);
        result_next.fixed_z = apply_shift(item.coord_z, lane_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            prev_reg         <= '0;
        end
        else if (load)
        begin
            result_valid_reg <= 1'b1;
            prev_reg         <= result_next;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign prev         = prev_reg;

endmodule

### design/periodic_coordinate_unwrap_unit.sv
// periodic_coordinate_unwrap_unit: minimum-image unwrapping of an atom chain.
// Each axis lane runs a 34-step restoring divider; the unit takes a new item only
// after the lanes' results for the last one are merged. First-atom items, and items
// whose every axis has a zero cell length, skip the divider. Reset (async, active low)
// sets all cell lengths to 1.0, the chain to zero, and empties the result register.
// Depends on pcu_pkg, pcu_lane, pcu_merge.

module periodic_coordinate_unwrap_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           item_valid,
    output logic                           item_ready,
    input  pcu_pkg::item_t                 item,
    // result channel
    output logic                           result_valid,
    input  logic                           result_ready,
    output pcu_pkg::result_t               result,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [pcu_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [pcu_pkg::LenW-1:0]       cfg_data
);

    // cell length of 1.0 in the coordinate format
    localparam logic [pcu_pkg::LenW-1:0] LenReset = pcu_pkg::LenW'(64'd1 << FRACTION_BITS);

    logic [pcu_pkg::LenW-1:0] len_x_reg;
    logic [pcu_pkg::LenW-1:0] len_y_reg;
    logic [pcu_pkg::LenW-1:0] len_z_reg;

    logic                     busy_reg;
    pcu_pkg::item_t           item_reg;

    logic                     accept;
    logic                     load;
    pcu_pkg::lane_status_t    lane_x;
    pcu_pkg::lane_status_t    lane_y;
    pcu_pkg::lane_status_t    lane_z;
    pcu_pkg::result_t         prev;

    // Take a new item only once the lanes are free; the result register
    // parts the two sides, so an item may start while a result waits.
    assign item_ready = !busy_reg;
    assign accept     = item_valid && item_ready;

    // Merge when every lane is done and the result register can take it.
    assign load = busy_reg && lane_x.done && lane_y.done && lane_z.done
                  && (!result_valid || result_ready);

    // Configuration writes: indexes past the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_x_reg <= LenReset;
            len_y_reg <= LenReset;
            len_z_reg <= LenReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcu_pkg::CfgLenX: len_x_reg <= cfg_data;
                pcu_pkg::CfgLenY: len_y_reg <= cfg_data;
                pcu_pkg::CfgLenZ: len_z_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Hold busy from the input transfer until the merge stage takes the lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (accept)
            busy_reg <= 1'b1;
        else if (load)
            busy_reg <= 1'b0;
    end

    // Hold the accepted item for the lanes and the merge stage.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    // One lane per axis; each works against the previous corrected coordinate.
    pcu_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .ack    (load),
        .coord  (item_reg.coord_x),
        .prev   (prev.fixed_x),
        .len    (len_x_reg),
        .first  (item_reg.first_atom),
        .status (lane_x)
    );

    pcu_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .ack    (load),
        .coord  (item_reg.coord_y),
        .prev   (prev.fixed_y),
        .len    (len_y_reg),
        .first  (item_reg.first_atom),
        .status (lane_y)
    );

    pcu_lane u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .ack    (load),
        .coord  (item_reg.coord_z),
        .prev   (prev.fixed_z),
        .len    (len_z_reg),
        .first  (item_reg.first_atom),
        .status (lane_z)
    );

    // Apply the shifts, saturate, advance the chain and present the result.
    pcu_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .item         (item_reg),
        .lane_x       (lane_x),
        .lane_y       (lane_y),
        .lane_z       (lane_z),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .prev         (prev)
    );

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for periodic_coordinate_unwrap_unit.
// Drives a directed table and random atom chains, predicts every unwrapped triple.
// Depends on pcu_pkg and periodic_coordinate_unwrap_unit.

module tb_top;

    // quiet cycles tolerated before the run is called hung; covers the long
    // receiver hold-off plus a drain of the block
    localparam int QuietLimit   = 2000;
    localparam int HoldOffAt    = 150;
    localparam int HoldOffLen   = 300;
    localparam int RandomPhases = 15;
    localparam int PhaseAtoms   = 30;
    localparam logic [pcu_pkg::LenW-1:0] LenOne = 31'h0001_0000;
    localparam logic [pcu_pkg::LenW-1:0] LenMax = 31'h7FFF_FFFF;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         item_valid   = 1'b0;
    logic                         item_ready;
    pcu_pkg::item_t               item         = '0;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    pcu_pkg::result_t             result;
    logic                         cfg_we       = 1'b0;
    logic [pcu_pkg::CfgIdxW-1:0]  cfg_index    = pcu_pkg::CfgLenX;
    logic [pcu_pkg::LenW-1:0]     cfg_data     = '0;

    // shadow of the block: cell lengths and the corrected chain position
    logic [pcu_pkg::LenW-1:0]          box_len   [3];
    logic signed [pcu_pkg::CoordW-1:0] chain_pos [3];

    pcu_pkg::result_t expected_fixed [$];
    int               errors       = 0;
    int               quiet_cycles = 0;
    bit               steady       = 1'b0;   // both sides skip idling while set

    typedef struct {
        bit                       set_len;
        logic [pcu_pkg::LenW-1:0] len_x;
        logic [pcu_pkg::LenW-1:0] len_y;
        logic [pcu_pkg::LenW-1:0] len_z;
        pcu_pkg::item_t           atom;
        bit                       typed;
        pcu_pkg::result_t         want;
    } vec_row_t;

    vec_row_t directed_rows [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    periodic_coordinate_unwrap_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Minimum-image correction of one axis: subtract the cell count nearest
    // to the difference, ties away from zero, then clamp to 32 bits.
    // A zero length leaves the raw coordinate alone.
    function automatic logic signed [pcu_pkg::CoordW-1:0] nearest_image(
        input logic signed [pcu_pkg::CoordW-1:0] raw,
        input logic signed [pcu_pkg::CoordW-1:0] ref_pos,
        input logic [pcu_pkg::LenW-1:0]          len
    );
        longint diff, mag, cells, shift, full;
        if (len == '0)
            return raw;
        diff  = longint'(raw) - longint'(ref_pos);
        mag   = (diff < 0) ? -diff : diff;
        cells = (2 * mag + longint'(len)) / (2 * longint'(len));
        shift = cells * longint'(len);
        if (diff < 0)
            shift = -shift;
        full = longint'(raw) - shift;
        if (full > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (full < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(full);
    endfunction

    // Advance the shadow chain by one atom and return the corrected triple.
    function automatic pcu_pkg::result_t predict_unwrap(input pcu_pkg::item_t atom);
        pcu_pkg::result_t                  fixed;
        logic signed [pcu_pkg::CoordW-1:0] pos [3];
        pos[0] = atom.coord_x;
        pos[1] = atom.coord_y;
        pos[2] = atom.coord_z;
        for (int i = 0; i < 3; i++)
        begin
            // a first atom restarts the chain unchanged
            if (!atom.first_atom)
                pos[i] = nearest_image(pos[i], chain_pos[i], box_len[i]);
            chain_pos[i] = pos[i];
        end
        fixed.fixed_x = pos[0];
        fixed.fixed_y = pos[1];
        fixed.fixed_z = pos[2];
        return fixed;
    endfunction

    // Pick a coordinate around the current chain position: mostly a few
    // cells away with rounding ties, else full-range noise or an edge value.
    function automatic logic signed [pcu_pkg::CoordW-1:0] draw_coord(
        input logic signed [pcu_pkg::CoordW-1:0] base,
        input logic [pcu_pkg::LenW-1:0]          len
    );
        longint span, off;
        int     pick;
        pick = $urandom_range(0, 99);
        span = (len == '0) ? 64'sd65536 : longint'(len);
        if (pick < 65)
        begin
            off = (longint'($urandom_range(0, 6)) - 3) * span;
            case ($urandom_range(0, 3))
                0: off += span / 2;
                1: off -= span / 2;
                default: off += longint'($urandom_range(32'(span), 0)) - span / 2;
            endcase
            return 32'(longint'(base) + off);
        end
        if (pick < 88)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return 32'shFFFF_FFFF;
            default: return base;
        endcase
    endfunction

    function automatic pcu_pkg::item_t draw_atom(input bit restart);
        pcu_pkg::item_t atom;
        atom.first_atom = restart || ($urandom_range(0, 99) < 8);
        atom.coord_x    = draw_coord(chain_pos[0], box_len[0]);
        atom.coord_y    = draw_coord(chain_pos[1], box_len[1]);
        atom.coord_z    = draw_coord(chain_pos[2], box_len[2]);
        return atom;
    endfunction

    function automatic logic [pcu_pkg::LenW-1:0] draw_length();
        case ($urandom_range(0, 7))
            0: return 31'd1;
            1: return LenMax;
            2: return '0;
            3: return 31'($urandom_range(1, 32'h0010_0000));
            4: return 31'($urandom_range(1, 64)) << 16;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic add_row(
        input bit set_len,
        input logic [pcu_pkg::LenW-1:0] lx, ly, lz,
        input logic signed [pcu_pkg::CoordW-1:0] cx, cy, cz,
        input bit first,
        input bit typed,
        input logic signed [pcu_pkg::CoordW-1:0] wx, wy, wz
    );
        vec_row_t row;
        row.set_len          = set_len;
        row.len_x            = lx;
        row.len_y            = ly;
        row.len_z            = lz;
        row.atom.coord_x     = cx;
        row.atom.coord_y     = cy;
        row.atom.coord_z     = cz;
        row.atom.first_atom  = first;
        row.typed            = typed;
        row.want.fixed_x     = wx;
        row.want.fixed_y     = wy;
        row.want.fixed_z     = wz;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic write_len(
        input logic [pcu_pkg::CfgIdxW-1:0] idx,
        input logic [pcu_pkg::LenW-1:0]    len
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= len;
        @(posedge clk);
    endtask

    // Reprogram all three lengths once the block has drained.
    task automatic apply_lengths(input logic [pcu_pkg::LenW-1:0] lx, ly, lz);
        item_valid <= 1'b0;
        while (expected_fixed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        write_len(pcu_pkg::CfgLenX, lx);
        write_len(pcu_pkg::CfgLenY, ly);
        write_len(pcu_pkg::CfgLenZ, lz);
        cfg_we     <= 1'b0;
        box_len[0] = lx;
        box_len[1] = ly;
        box_len[2] = lz;
    endtask

    // Offer one atom after a random gap and hold it until the transfer.
    // Valid drops only when a gap is drawn, so back-to-back atoms keep it high.
    task automatic offer_atom(
        input pcu_pkg::item_t   atom,
        input bit               typed,
        input pcu_pkg::result_t typed_val
    );
        int               gap;
        pcu_pkg::result_t predicted;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= atom;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predicted = predict_unwrap(atom);
        expected_fixed.insert(expected_fixed.size(), typed ? typed_val : predicted);
    endtask

    task automatic check_field(
        input string name,
        input logic signed [pcu_pkg::CoordW-1:0] want,
        input logic signed [pcu_pkg::CoordW-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Stimulus side: reset, directed table, random phases, then drain and judge.
    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            box_len[i]   = LenOne;
            chain_pos[i] = '0;
        end

        // reset lengths of 1.0: the chain starts against zero, ties round away
        add_row(0, '0, '0, '0, 32'sh0001_8000, 32'sh0000_0000, 32'shFFFE_8000, 0,
                1, 32'shFFFF_8000, 32'sh0000_0000, 32'sh0000_8000);
        add_row(0, '0, '0, '0, 32'sh0001_8000, 32'sh0000_FFFF, 32'sh7FFF_FFFF, 0,
                0, '0, '0, '0);
        // first atom at the extremes passes through
        add_row(0, '0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1,
                1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
        // widest possible differences
        add_row(0, '0, '0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 0,
                0, '0, '0, '0);
        add_row(0, '0, '0, '0, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1,
                1, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        // exact half cell both ways, and just under half
        add_row(0, '0, '0, '0, 32'sh0000_8000, 32'shFFFF_8000, 32'sh0000_7FFF, 0,
                1, 32'shFFFF_8000, 32'sh0000_8000, 32'sh0000_7FFF);
        // zero length on x, largest on y, smallest on z
        add_row(1, '0, LenMax, 31'd1, 32'sh1234_5678, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                0, '0, '0, '0);
        add_row(0, '0, '0, '0, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                0, '0, '0, '0);
        add_row(0, '0, '0, '0, 32'shA5A5_A5A5, 32'sh5A5A_5A5A, 32'sh0001_0001, 0,
                0, '0, '0, '0);
        // largest lengths: saturate at both ends
        add_row(1, LenMax, LenMax, LenMax, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1,
                1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
        add_row(0, '0, '0, '0, 32'sh3FFF_FFFF, 32'sh4000_0000, 32'sh7FFF_FFFF, 0,
                1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
        add_row(0, '0, '0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                0, '0, '0, '0);
        add_row(0, '0, '0, '0, 32'shC000_0000, 32'sh3FFF_FFFF, 32'sh0000_0001, 0,
                0, '0, '0, '0);
        // back to 1.0: an unchanged coordinate after a first atom stays put
        add_row(1, LenOne, LenOne, LenOne, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0002_0000, 1,
                1, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0002_0000);
        add_row(0, '0, '0, '0, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0002_0000, 0,
                1, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0002_0000);
        add_row(0, '0, '0, '0, 32'sh7FFF_8000, 32'sh8000_8000, 32'sh0000_0000, 0,
                0, '0, '0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].set_len)
                apply_lengths(directed_rows[r].len_x, directed_rows[r].len_y,
                              directed_rows[r].len_z);
            offer_atom(directed_rows[r].atom, directed_rows[r].typed, directed_rows[r].want);
        end

        // random chains, each phase under its own lengths; the first two pin
        // the extremes, even phases open with a first atom, every fifth runs
        // with no idling on either side
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            case (phase)
                0: apply_lengths(31'd1, LenMax, '0);
                1: apply_lengths(LenMax, '0, 31'd1);
                default: apply_lengths(draw_length(), draw_length(), draw_length());
            endcase
            steady = (phase % 5 == 3);
            for (int k = 0; k < PhaseAtoms; k++)
                offer_atom(draw_atom(k == 0 && phase % 2 == 0), 1'b0, '0);
        end

        // drop valid, drain, then keep the clock running to catch stray results
        item_valid <= 1'b0;
        steady     = 1'b0;
        while (expected_fixed.size() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Result side: stall at random, hold off once for a long stretch so the
    // block backs up into its input, and compare each transfer in order.
    initial
    begin : result_side
        int               stall;
        int               results_seen;
        pcu_pkg::result_t got;
        pcu_pkg::result_t want;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 11);
            if (results_seen == HoldOffAt)
                stall = HoldOffLen;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            got = result;
            results_seen++;
            if (expected_fixed.size() == 0)
            begin
                $error("result with no atom waiting: %h", got);
                errors++;
            end
            else
            begin
                want = expected_fixed.pop_front();
                check_field("fixed_x", want.fixed_x, got.fixed_x);
                check_field("fixed_y", want.fixed_y, got.fixed_y);
                check_field("fixed_z", want.fixed_z, got.fixed_z);
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QuietLimit)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule

### files.f
design/pcu_pkg.sv
design/pcu_lane.sv
design/pcu_merge.sv
design/periodic_coordinate_unwrap_unit.sv
tb/tb_top.sv
